// ----- hw/rtl/usrs_pkg.sv -----
// Package for the ultrasonic ranging sequencer: widths, reset values,
// sensor, command and register codes, and the result struct.
// No dependencies.
`default_nettype none

package usrs_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int SCALE_W     = 16;
  localparam int DIST_W      = 18;
  localparam int SENS_W      = 2;
  localparam int CFG_IDX_W   = 2;

  localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(557);
  localparam logic [DIST_W-1:0]  OFFSET_RESET = DIST_W'(10240);
  localparam logic [DIST_W-1:0]  MAXD_RESET   = DIST_W'(128000);
  localparam logic [DIST_W-1:0]  DIST_MAX     = {DIST_W{1'b1}};

  localparam logic [SENS_W-1:0] SENSOR_FRONT = 2'd0;
  localparam logic [SENS_W-1:0] SENSOR_BACK  = 2'd1;
  localparam logic [SENS_W-1:0] SENSOR_LEFT  = 2'd2;
  localparam logic [SENS_W-1:0] SENSOR_RIGHT = 2'd3;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_EDGE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAXD   = 2'd2;

  typedef struct packed {
    logic              trigger_valid;
    logic [SENS_W-1:0] trigger_sensor;
    logic              dist_valid;
    logic [SENS_W-1:0] dist_sensor;
    logic [DIST_W-1:0] distance;
    logic              timed_out;
  } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/usrs_dist.sv -----
// Distance arithmetic: wrapped count difference, scaling, offset and
// saturation. Depends on usrs_pkg.
`default_nettype none

module usrs_dist (
  input  wire logic [usrs_pkg::COUNT_WIDTH-1:0] now,
  input  wire logic [usrs_pkg::COUNT_WIDTH-1:0] start_count,
  input  wire logic [usrs_pkg::SCALE_W-1:0]     scale,
  input  wire logic [usrs_pkg::DIST_W-1:0]      offset,
  output logic      [usrs_pkg::DIST_W-1:0]      distance
);

  localparam int PROD_W = usrs_pkg::COUNT_WIDTH + usrs_pkg::SCALE_W;
  localparam int RAW_W  = PROD_W - 8;
  localparam int EXT_W  = (RAW_W > usrs_pkg::DIST_W) ? RAW_W : usrs_pkg::DIST_W + 1;

  logic [usrs_pkg::COUNT_WIDTH-1:0] diff;
  logic [PROD_W-1:0]                prod;
  logic [EXT_W-1:0]                 raw_ext;
  logic [EXT_W-1:0]                 off_ext;
  logic [EXT_W-1:0]                 net;

  always_comb begin
    diff    = now - start_count;
    prod    = PROD_W'(diff) * PROD_W'(scale);
    raw_ext = EXT_W'(prod[PROD_W-1:8]);
    off_ext = EXT_W'(offset);
    // Offset at or above the raw value clamps to zero.
    net     = (raw_ext > off_ext) ? (raw_ext - off_ext) : '0;
    if (|net[EXT_W-1:usrs_pkg::DIST_W]) begin
      distance = usrs_pkg::DIST_MAX;
    end else begin
      distance = net[usrs_pkg::DIST_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/usrs_seq.sv -----
// Ten-phase ranging sequencer: phase and start count registers and the
// decision logic for one request. Depends on usrs_pkg.
`default_nettype none

module usrs_seq (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             advance,
  input  wire logic                             command,
  input  wire logic [usrs_pkg::SENS_W-1:0]      sensor,
  input  wire logic                             echo_level,
  input  wire logic [usrs_pkg::COUNT_WIDTH-1:0] timer_count,
  input  wire logic [usrs_pkg::DIST_W-1:0]      max_distance,
  input  wire logic [usrs_pkg::DIST_W-1:0]      measured,
  output logic      [usrs_pkg::COUNT_WIDTH-1:0] start_count,
  output usrs_pkg::res_t                        res
);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_F_RISE = 4'd1,
    PH_F_FALL = 4'd2,
    PH_F_DONE = 4'd3,
    PH_B_RISE = 4'd4,
    PH_B_FALL = 4'd5,
    PH_B_DONE = 4'd6,
    PH_L_MEAS = 4'd7,
    PH_L_DONE = 4'd8,
    PH_R_MEAS = 4'd9
  } phase_t;

  phase_t                           phase_r, phase_nxt;
  logic [usrs_pkg::COUNT_WIDTH-1:0] start_r, start_nxt;

  assign start_count = start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      start_r <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      start_r <= start_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    start_nxt = start_r;
    res       = '0;
    if (command == usrs_pkg::CMD_TICK) begin
      res.trigger_valid = 1'b1;
      case (phase_r)
        PH_F_RISE, PH_F_FALL: begin
          res.dist_valid     = 1'b1;
          res.dist_sensor    = usrs_pkg::SENSOR_FRONT;
          res.distance       = max_distance;
          res.timed_out      = 1'b1;
          res.trigger_sensor = usrs_pkg::SENSOR_BACK;
          phase_nxt          = PH_B_RISE;
        end
        PH_F_DONE: begin
          res.trigger_sensor = usrs_pkg::SENSOR_BACK;
          phase_nxt          = PH_B_RISE;
        end
        PH_B_RISE, PH_B_FALL: begin
          res.dist_valid     = 1'b1;
          res.dist_sensor    = usrs_pkg::SENSOR_BACK;
          res.distance       = max_distance;
          res.timed_out      = 1'b1;
          res.trigger_sensor = usrs_pkg::SENSOR_LEFT;
          start_nxt          = timer_count;
          phase_nxt          = PH_L_MEAS;
        end
        PH_B_DONE: begin
          res.trigger_sensor = usrs_pkg::SENSOR_LEFT;
          start_nxt          = timer_count;
          phase_nxt          = PH_L_MEAS;
        end
        PH_L_MEAS: begin
          res.dist_valid     = 1'b1;
          res.dist_sensor    = usrs_pkg::SENSOR_LEFT;
          res.distance       = max_distance;
          res.timed_out      = 1'b1;
          res.trigger_sensor = usrs_pkg::SENSOR_RIGHT;
          start_nxt          = timer_count;
          phase_nxt          = PH_R_MEAS;
        end
        PH_L_DONE: begin
          res.trigger_sensor = usrs_pkg::SENSOR_RIGHT;
          start_nxt          = timer_count;
          phase_nxt          = PH_R_MEAS;
        end
        PH_R_MEAS: begin
          res.dist_valid     = 1'b1;
          res.dist_sensor    = usrs_pkg::SENSOR_RIGHT;
          res.distance       = max_distance;
          res.timed_out      = 1'b1;
          res.trigger_sensor = usrs_pkg::SENSOR_FRONT;
          phase_nxt          = PH_F_RISE;
        end
        default: begin
          res.trigger_sensor = usrs_pkg::SENSOR_FRONT;
          phase_nxt          = PH_F_RISE;
        end
      endcase
    end else begin
      // Edges that the current phase does not wait for leave the state alone.
      case (sensor)
        usrs_pkg::SENSOR_FRONT: begin
          if (phase_r == PH_F_RISE && echo_level) begin
            start_nxt = timer_count;
            phase_nxt = PH_F_FALL;
          end else if (phase_r == PH_F_FALL && !echo_level) begin
            res.dist_valid  = 1'b1;
            res.dist_sensor = usrs_pkg::SENSOR_FRONT;
            res.distance    = measured;
            phase_nxt       = PH_F_DONE;
          end
        end
        usrs_pkg::SENSOR_BACK: begin
          if (phase_r == PH_B_RISE && echo_level) begin
            start_nxt = timer_count;
            phase_nxt = PH_B_FALL;
          end else if (phase_r == PH_B_FALL && !echo_level) begin
            res.dist_valid  = 1'b1;
            res.dist_sensor = usrs_pkg::SENSOR_BACK;
            res.distance    = measured;
            phase_nxt       = PH_B_DONE;
          end
        end
        usrs_pkg::SENSOR_LEFT: begin
          if (phase_r == PH_L_MEAS) begin
            res.dist_valid  = 1'b1;
            res.dist_sensor = usrs_pkg::SENSOR_LEFT;
            res.distance    = measured;
            phase_nxt       = PH_L_DONE;
          end
        end
        default: begin
          if (phase_r == PH_R_MEAS) begin
            res.dist_valid  = 1'b1;
            res.dist_sensor = usrs_pkg::SENSOR_RIGHT;
            res.distance    = measured;
            phase_nxt       = PH_IDLE;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/four_sensor_ultrasonic_ranging_sequencer.sv -----
// Top level of the four-sensor ultrasonic ranging sequencer: request and
// result registers, configuration registers. Depends on usrs_pkg,
// usrs_dist and usrs_seq.
//
// Usage: each request on the in_ channel is either a periodic tick
// (in_command 0) or an echo pin edge (in_command 1) with the timer value
// sampled at that event. Every request yields exactly one result on the
// out_ channel, which may carry a trigger order, a distance, or nothing.
// A request is captured in an input register and processed when it moves
// into the result register through one 16x16 multiply, an offset subtract
// and a saturating compare; out_valid rises once it is in the result register.
// Throughput is one request per cycle while out_ready stays high.
// When the receiver stalls, the result register holds, the input register
// holds one more request, and in_ready falls until the result is taken.
// The cfg_ channel is always ready; writes take effect the next cycle and
// are meant to happen only while the block is idle. Indexes past the last
// register are ignored.
// Reset (synchronous, rst_n low) empties both registers, returns the
// sequencer to its idle phase with a zero start count and loads the
// configuration registers with their defaults.
`default_nettype none

module four_sensor_ultrasonic_ranging_sequencer (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_command,
  input  wire logic [usrs_pkg::SENS_W-1:0]      in_sensor,
  input  wire logic                             in_echo_level,
  input  wire logic [usrs_pkg::COUNT_WIDTH-1:0] in_timer_count,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_trigger_valid,
  output logic      [usrs_pkg::SENS_W-1:0]      out_trigger_sensor,
  output logic                                  out_dist_valid,
  output logic      [usrs_pkg::SENS_W-1:0]      out_dist_sensor,
  output logic      [usrs_pkg::DIST_W-1:0]      out_distance,
  output logic                                  out_timed_out,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [usrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [usrs_pkg::DIST_W-1:0]      cfg_data
);

  logic [usrs_pkg::SCALE_W-1:0] scale_r;
  logic [usrs_pkg::DIST_W-1:0]  offset_r;
  logic [usrs_pkg::DIST_W-1:0]  maxd_r;

  logic                             s1_valid_r;
  logic                             s1_command_r;
  logic [usrs_pkg::SENS_W-1:0]      s1_sensor_r;
  logic                             s1_level_r;
  logic [usrs_pkg::COUNT_WIDTH-1:0] s1_count_r;

  logic           out_valid_r;
  usrs_pkg::res_t out_res_r;
  usrs_pkg::res_t res;

  logic                             advance;
  logic [usrs_pkg::COUNT_WIDTH-1:0] start_count;
  logic [usrs_pkg::DIST_W-1:0]      measured;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= usrs_pkg::SCALE_RESET;
      offset_r <= usrs_pkg::OFFSET_RESET;
      maxd_r   <= usrs_pkg::MAXD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        usrs_pkg::REG_SCALE:  scale_r  <= cfg_data[usrs_pkg::SCALE_W-1:0];
        usrs_pkg::REG_OFFSET: offset_r <= cfg_data;
        usrs_pkg::REG_MAXD:   maxd_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_command_r <= in_command;
      s1_sensor_r  <= in_sensor;
      s1_level_r   <= in_echo_level;
      s1_count_r   <= in_timer_count;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  usrs_dist u_dist (
    .now         (s1_count_r),
    .start_count (start_count),
    .scale       (scale_r),
    .offset      (offset_r),
    .distance    (measured)
  );

  usrs_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .command      (s1_command_r),
    .sensor       (s1_sensor_r),
    .echo_level   (s1_level_r),
    .timer_count  (s1_count_r),
    .max_distance (maxd_r),
    .measured     (measured),
    .start_count  (start_count),
    .res          (res)
  );

  assign out_valid          = out_valid_r;
  assign out_trigger_valid  = out_res_r.trigger_valid;
  assign out_trigger_sensor = out_res_r.trigger_sensor;
  assign out_dist_valid     = out_res_r.dist_valid;
  assign out_dist_sensor    = out_res_r.dist_sensor;
  assign out_distance       = out_res_r.distance;
  assign out_timed_out      = out_res_r.timed_out;

endmodule

`default_nettype wire

// ----- tb/sv/four_sensor_ultrasonic_ranging_sequencer_checker.sv -----
// Checker for the ultrasonic ranging sequencer: tracks the sequencer phase,
// start count and configuration, predicts every result and compares it.
// Depends on usrs_pkg.
`default_nettype none

module four_sensor_ultrasonic_ranging_sequencer_checker import usrs_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   in_ready,
  input  wire logic                   in_command,
  input  wire logic [SENS_W-1:0]      in_sensor,
  input  wire logic                   in_echo_level,
  input  wire logic [COUNT_WIDTH-1:0] in_timer_count,
  input  wire logic                   out_valid,
  input  wire logic                   out_ready,
  input  wire logic                   out_trigger_valid,
  input  wire logic [SENS_W-1:0]      out_trigger_sensor,
  input  wire logic                   out_dist_valid,
  input  wire logic [SENS_W-1:0]      out_dist_sensor,
  input  wire logic [DIST_W-1:0]      out_distance,
  input  wire logic                   out_timed_out,
  input  wire logic                   cfg_valid,
  input  wire logic                   cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [DIST_W-1:0]      cfg_data,
  output int                          fail_count,
  output int                          pending_results,
  output int                          results_checked,
  output int                          echo_readings,
  output int                          no_echo_readings
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTED = 40;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_FRONT_RISE = 4'd1,
    PH_FRONT_FALL = 4'd2,
    PH_FRONT_DONE = 4'd3,
    PH_BACK_RISE  = 4'd4,
    PH_BACK_FALL  = 4'd5,
    PH_BACK_DONE  = 4'd6,
    PH_LEFT_WAIT  = 4'd7,
    PH_LEFT_DONE  = 4'd8,
    PH_RIGHT_WAIT = 4'd9
  } seq_phase_e;

  seq_phase_e             phase_q;
  logic [COUNT_WIDTH-1:0] start_count_q;
  logic [SCALE_W-1:0]     scale_q;
  logic [DIST_W-1:0]      offset_q;
  logic [DIST_W-1:0]      max_dist_q;
  res_t                   expected_readings[$];

  initial begin
    fail_count       = 0;
    pending_results  = 0;
    results_checked  = 0;
    echo_readings    = 0;
    no_echo_readings = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTED) begin
      $display("[%0t] ranging mismatch: %s", $time, msg);
    end
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // Elapsed count wraps at the counter width, then scaled to 1/256 cm.
  function automatic logic [DIST_W-1:0] echo_distance(input logic [COUNT_WIDTH-1:0] now);
    logic [COUNT_WIDTH-1:0]         elapsed;
    logic [COUNT_WIDTH+SCALE_W-1:0] product;
    logic [COUNT_WIDTH+SCALE_W-1:0] raw;
    logic [COUNT_WIDTH+SCALE_W-1:0] net;
    elapsed = now - start_count_q;
    product = elapsed * scale_q;
    raw = product >> 8;
    if (raw <= offset_q) begin
      return '0;
    end
    net = raw - offset_q;
    if (net > DIST_MAX) begin
      return DIST_MAX;
    end
    return net[DIST_W-1:0];
  endfunction

  task automatic mark_no_echo(inout res_t r, input logic [SENS_W-1:0] sens);
    r.dist_valid  = 1'b1;
    r.dist_sensor = sens;
    r.distance    = max_dist_q;
    r.timed_out   = 1'b1;
  endtask

  task automatic mark_echo(inout res_t r, input logic [SENS_W-1:0] sens,
                           input logic [COUNT_WIDTH-1:0] now);
    r.dist_valid  = 1'b1;
    r.dist_sensor = sens;
    r.distance    = echo_distance(now);
  endtask

  task automatic step_sequencer(input logic cmd, input logic [SENS_W-1:0] sens,
                                input logic level, input logic [COUNT_WIDTH-1:0] now,
                                output res_t r);
    r = '0;
    if (cmd == CMD_TICK) begin
      r.trigger_valid = 1'b1;
      case (phase_q)
        PH_FRONT_RISE, PH_FRONT_FALL, PH_FRONT_DONE: begin
          if (phase_q != PH_FRONT_DONE) mark_no_echo(r, SENSOR_FRONT);
          r.trigger_sensor = SENSOR_BACK;
          phase_q = PH_BACK_RISE;
        end
        // Left and right time from their own trigger, so the tick loads the start.
        PH_BACK_RISE, PH_BACK_FALL, PH_BACK_DONE: begin
          if (phase_q != PH_BACK_DONE) mark_no_echo(r, SENSOR_BACK);
          r.trigger_sensor = SENSOR_LEFT;
          start_count_q = now;
          phase_q = PH_LEFT_WAIT;
        end
        PH_LEFT_WAIT, PH_LEFT_DONE: begin
          if (phase_q == PH_LEFT_WAIT) mark_no_echo(r, SENSOR_LEFT);
          r.trigger_sensor = SENSOR_RIGHT;
          start_count_q = now;
          phase_q = PH_RIGHT_WAIT;
        end
        PH_RIGHT_WAIT: begin
          mark_no_echo(r, SENSOR_RIGHT);
          r.trigger_sensor = SENSOR_FRONT;
          phase_q = PH_FRONT_RISE;
        end
        default: begin
          r.trigger_sensor = SENSOR_FRONT;
          phase_q = PH_FRONT_RISE;
        end
      endcase
    end else begin
      case (sens)
        SENSOR_FRONT: begin
          if (phase_q == PH_FRONT_RISE && level) begin
            start_count_q = now;
            phase_q = PH_FRONT_FALL;
          end else if (phase_q == PH_FRONT_FALL && !level) begin
            mark_echo(r, SENSOR_FRONT, now);
            phase_q = PH_FRONT_DONE;
          end
        end
        SENSOR_BACK: begin
          if (phase_q == PH_BACK_RISE && level) begin
            start_count_q = now;
            phase_q = PH_BACK_FALL;
          end else if (phase_q == PH_BACK_FALL && !level) begin
            mark_echo(r, SENSOR_BACK, now);
            phase_q = PH_BACK_DONE;
          end
        end
        SENSOR_LEFT: begin
          if (phase_q == PH_LEFT_WAIT) begin
            mark_echo(r, SENSOR_LEFT, now);
            phase_q = PH_LEFT_DONE;
          end
        end
        default: begin
          if (phase_q == PH_RIGHT_WAIT) begin
            mark_echo(r, SENSOR_RIGHT, now);
            phase_q = PH_IDLE;
          end
        end
      endcase
    end
  endtask

  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    res_t fresh;
    if (!rst_n) begin
      phase_q       = PH_IDLE;
      start_count_q = '0;
      scale_q       = SCALE_RESET;
      offset_q      = OFFSET_RESET;
      max_dist_q    = MAXD_RESET;
      expected_readings.delete();
    end else begin
      // Results leave through the input and result registers after their request, so compare before pushing.
      if (out_valid && out_ready) begin
        got = '{out_trigger_valid, out_trigger_sensor, out_dist_valid,
                out_dist_sensor, out_distance, out_timed_out};
        if (expected_readings.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = expected_readings.pop_front();
          check_field("trigger_valid", got.trigger_valid, want.trigger_valid);
          check_field("trigger_sensor", got.trigger_sensor, want.trigger_sensor);
          check_field("dist_valid", got.dist_valid, want.dist_valid);
          check_field("dist_sensor", got.dist_sensor, want.dist_sensor);
          check_field("distance", got.distance, want.distance);
          check_field("timed_out", got.timed_out, want.timed_out);
          results_checked++;
          if (want.timed_out) begin
            no_echo_readings++;
          end else if (want.dist_valid) begin
            echo_readings++;
          end
        end
      end
      if (in_valid && in_ready) begin
        step_sequencer(in_command, in_sensor, in_echo_level, in_timer_count, fresh);
        expected_readings.push_back(fresh);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCALE:  scale_q = cfg_data[SCALE_W-1:0];
          REG_OFFSET: offset_q = cfg_data;
          REG_MAXD:   max_dist_q = cfg_data;
          default:    ;
        endcase
      end
    end
    pending_results = expected_readings.size();
  end

endmodule

`default_nettype wire

// ----- tb/sv/four_sensor_ultrasonic_ranging_sequencer_test.sv -----
// Top of the ranging sequencer testbench: clock, reset, request, result and
// configuration traffic, and the verdict. Depends on usrs_pkg, the sequencer
// and four_sensor_ultrasonic_ranging_sequencer_checker.
`default_nettype none

module four_sensor_ultrasonic_ranging_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import usrs_pkg::*;

  localparam int                   IDLE_LIMIT  = 4000;
  localparam int                   HOLD_CYCLES = 300;
  localparam int                   PHASE_ITEMS = 200;
  localparam int                   NUM_PHASES  = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_command = CMD_TICK;
  logic [SENS_W-1:0]      in_sensor = SENSOR_FRONT;
  logic                   in_echo_level = 1'b0;
  logic [COUNT_WIDTH-1:0] in_timer_count = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_trigger_valid;
  logic [SENS_W-1:0]      out_trigger_sensor;
  logic                   out_dist_valid;
  logic [SENS_W-1:0]      out_dist_sensor;
  logic [DIST_W-1:0]      out_distance;
  logic                   out_timed_out;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_SCALE;
  logic [DIST_W-1:0]      cfg_data = '0;

  int fail_count;
  int pending_results;
  int results_checked;
  int echo_readings;
  int no_echo_readings;

  int                     items_sent = 0;
  int                     settings_used = 0;
  int                     idle_cycles = 0;
  bit                     hold_req = 1'b0;
  bit                     tx_steady = 1'b0;
  bit                     rx_steady = 1'b0;
  logic [COUNT_WIDTH-1:0] timer_now = '0;

  four_sensor_ultrasonic_ranging_sequencer i_dut (.*);

  four_sensor_ultrasonic_ranging_sequencer_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: too many cycles without any accepted transfer ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("four_sensor_ultrasonic_ranging_sequencer verification failed");
      $finish;
    end
  end

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int draw_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else begin
        stall = draw_gap(rx_steady);
        if (stall == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic cmd, input logic [SENS_W-1:0] sens,
                           input logic level, input logic [COUNT_WIDTH-1:0] count);
    int gap;
    gap = draw_gap(tx_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_sensor      <= sens;
    in_echo_level  <= level;
    in_timer_count <= count;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIST_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // The spare index must be ignored by the block.
  task automatic apply_settings(input logic [DIST_W-1:0] scale, input logic [DIST_W-1:0] offset,
                                input logic [DIST_W-1:0] maxd);
    write_reg(REG_SCALE, scale);
    write_reg(REG_OFFSET, offset);
    write_reg(REG_MAXD, maxd);
    write_reg(REG_SPARE, DIST_W'($urandom()));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [COUNT_WIDTH-1:0] echo_width();
    if ($urandom_range(0, 4) == 0) return COUNT_WIDTH'($urandom());
    return COUNT_WIDTH'($urandom_range(4000, 30000));
  endfunction

  task automatic maybe_noise();
    if ($urandom_range(0, 9) == 0) begin
      timer_now += COUNT_WIDTH'($urandom_range(0, 2000));
      send_item(($urandom_range(0, 3) == 0) ? CMD_TICK : CMD_EDGE,
                SENS_W'($urandom()), 1'($urandom()), timer_now);
    end
  endtask

  task automatic send_tick();
    maybe_noise();
    timer_now += COUNT_WIDTH'($urandom_range(1, 3000));
    // Sensor and level are don't-cares on a tick; vary them anyway.
    send_item(CMD_TICK, SENS_W'($urandom()), 1'($urandom()), timer_now);
  endtask

  // Front and back: rising edge starts timing, falling edge ends it.
  task automatic time_pulse(input logic [SENS_W-1:0] sens);
    int form;
    form = $urandom_range(0, 9);
    if (form > 0) begin
      timer_now += COUNT_WIDTH'($urandom_range(0, 500));
      send_item(CMD_EDGE, sens, 1'b1, timer_now);
      maybe_noise();
      if (form > 1) begin
        timer_now += echo_width();
        send_item(CMD_EDGE, sens, 1'b0, timer_now);
      end
    end
  endtask

  // Left and right: any edge from the sensor ends timing.
  task automatic time_echo(input logic [SENS_W-1:0] sens);
    if ($urandom_range(0, 7) != 0) begin
      timer_now += echo_width();
      send_item(CMD_EDGE, sens, 1'($urandom()), timer_now);
    end
  endtask

  task automatic run_round();
    send_tick();
    time_pulse(SENSOR_FRONT);
    send_tick();
    time_pulse(SENSOR_BACK);
    send_tick();
    time_echo(SENSOR_LEFT);
    send_tick();
    time_echo(SENSOR_RIGHT);
  endtask

  initial begin
    int                k;
    int                target;
    logic [DIST_W-1:0] scale;
    logic [DIST_W-1:0] offset;
    logic [DIST_W-1:0] maxd;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed walk with the reset configuration.
    send_item(CMD_EDGE, SENSOR_FRONT, 1'b1, 16'h1234);   // edge while idle
    send_item(CMD_TICK, SENSOR_FRONT, 1'b0, 16'h0000);
    send_item(CMD_EDGE, SENSOR_FRONT, 1'b0, 16'h0001);   // wrong level
    send_item(CMD_EDGE, SENSOR_BACK, 1'b1, 16'h0002);    // sensor not awaited
    send_item(CMD_EDGE, SENSOR_FRONT, 1'b1, 16'hFFF0);
    send_item(CMD_EDGE, SENSOR_FRONT, 1'b0, 16'h0010);   // wraps, below offset
    send_item(CMD_TICK, SENSOR_RIGHT, 1'b1, 16'h0020);
    send_item(CMD_EDGE, SENSOR_BACK, 1'b1, 16'h0000);
    send_item(CMD_EDGE, SENSOR_BACK, 1'b0, 16'hFFFF);
    send_item(CMD_TICK, SENSOR_LEFT, 1'b0, 16'h0100);
    send_item(CMD_EDGE, SENSOR_LEFT, 1'b0, 16'h4000);
    send_item(CMD_EDGE, SENSOR_LEFT, 1'b1, 16'h4100);    // left already done
    send_item(CMD_TICK, SENSOR_FRONT, 1'b0, 16'h5000);
    send_item(CMD_TICK, SENSOR_FRONT, 1'b0, 16'h6000);   // right gave no echo
    send_item(CMD_TICK, SENSOR_FRONT, 1'b0, 16'h7000);   // front gave no echo
    send_item(CMD_EDGE, SENSOR_BACK, 1'b1, 16'h7100);
    send_item(CMD_TICK, SENSOR_FRONT, 1'b0, 16'h8000);   // back rose, never fell
    send_item(CMD_TICK, SENSOR_FRONT, 1'b0, 16'h9000);   // left gave no echo
    send_item(CMD_EDGE, SENSOR_RIGHT, 1'b1, 16'hC000);
    send_item(CMD_EDGE, SENSOR_RIGHT, 1'b0, 16'hC100);   // idle again
    send_item(CMD_TICK, SENSOR_FRONT, 1'b0, 16'hD000);
    send_item(CMD_EDGE, SENSOR_FRONT, 1'b1, 16'h0000);
    wait_drained();
    apply_settings(18'h3FFFF, '0, DIST_MAX);
    send_item(CMD_EDGE, SENSOR_FRONT, 1'b0, 16'hFFFF);   // saturates
    send_item(CMD_TICK, SENSOR_FRONT, 1'b0, 16'h0001);
    send_item(CMD_EDGE, SENSOR_BACK, 1'b1, 16'h0005);
    send_item(CMD_EDGE, SENSOR_BACK, 1'b0, 16'h0005);    // zero width, zero offset

    for (k = 0; k < NUM_PHASES; k++) begin
      wait_drained();
      case (k)
        0: begin
          scale = DIST_W'(SCALE_RESET);
          offset = OFFSET_RESET;
          maxd = MAXD_RESET;
        end
        1: begin scale = 18'h0FFFF; offset = '0; maxd = DIST_MAX; end
        2: begin scale = '0; offset = DIST_MAX; maxd = '0; end
        3: begin
          scale = DIST_W'($urandom_range(1, 64));
          offset = DIST_W'($urandom_range(0, 255));
          maxd = DIST_W'($urandom());
        end
        default: begin
          scale = DIST_W'($urandom());
          offset = DIST_W'($urandom_range(0, 40000));
          maxd = DIST_W'($urandom());
        end
      endcase
      apply_settings(scale, offset, maxd);
      tx_steady = (k == 1) || ($urandom_range(0, 3) == 0);
      rx_steady = (k == 1) || ($urandom_range(0, 3) == 0);
      if (k == 4) begin
        hold_req = 1'b1;
      end
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) run_round();
    end
    wait_drained();

    $display("Run covered %0d requests under %0d configuration settings.",
             items_sent, settings_used);
    $display("%0d results compared: %0d echo distances, %0d missing-echo reports.",
             results_checked, echo_readings, no_echo_readings);
    if (fail_count == 0) begin
      $display("four_sensor_ultrasonic_ranging_sequencer verification clean");
    end else begin
      $display("four_sensor_ultrasonic_ranging_sequencer verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
hw/rtl/usrs_pkg.sv
hw/rtl/usrs_dist.sv
hw/rtl/usrs_seq.sv
hw/rtl/four_sensor_ultrasonic_ranging_sequencer.sv
tb/sv/four_sensor_ultrasonic_ranging_sequencer_checker.sv
tb/sv/four_sensor_ultrasonic_ranging_sequencer_test.sv
